FILE: sv/texel_format_converter_assert.svh
`ifndef TEXEL_FORMAT_CONVERTER_ASSERT_SVH
`define TEXEL_FORMAT_CONVERTER_ASSERT_SVH

// same-cycle implication, checked on every rising clk edge out of reset
`define TFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising clk edge out of reset
`define TFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tfc_pkg.sv
`timescale 1ns / 1ps

package tfc_pkg;

  localparam int CHAN_W    = 16;
  localparam int TEXEL_W   = 16;
  localparam int SCALE_W   = 6;
  localparam int PROD_W    = CHAN_W + SCALE_W;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SOURCE_FORMAT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WITH_ALPHA    = 8'd1;

  typedef enum logic [1:0] {
    SRC_S8  = 2'd0,
    SRC_U8  = 2'd1,
    SRC_S16 = 2'd2,
    SRC_U16 = 2'd3
  } src_fmt_t;

  // full-scale value of a packed channel
  typedef enum logic [1:0] {
    MAX_15 = 2'd0,
    MAX_31 = 2'd1,
    MAX_63 = 2'd2
  } max_sel_t;

  typedef struct packed {
    src_fmt_t src_fmt;
    logic     with_alpha;
  } tfc_cfg_t;

endpackage

FILE: sv/tfc_cfg_regs.sv
`timescale 1ns / 1ps

module tfc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [tfc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tfc_pkg::CFG_DATA_W-1:0] wr_data,
  output tfc_pkg::tfc_cfg_t              cfg
);
  import tfc_pkg::*;

  src_fmt_t src_fmt_r, src_fmt_nxt;
  logic     with_alpha_r, with_alpha_nxt;

  always_comb begin
    src_fmt_nxt    = src_fmt_r;
    with_alpha_nxt = with_alpha_r;
    if (wr_en) begin
      if (wr_index == CFG_IDX_SOURCE_FORMAT) begin
        src_fmt_nxt = src_fmt_t'(wr_data[1:0]);
      end else if (wr_index == CFG_IDX_WITH_ALPHA) begin
        with_alpha_nxt = wr_data[0];
      end
      // other indexes are ignored
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r    <= SRC_U8;
      with_alpha_r <= 1'b0;
    end else begin
      src_fmt_r    <= src_fmt_nxt;
      with_alpha_r <= with_alpha_nxt;
    end
  end

  assign cfg.src_fmt    = src_fmt_r;
  assign cfg.with_alpha = with_alpha_r;

endmodule

FILE: sv/tfc_chan_scale.sv
`timescale 1ns / 1ps

module tfc_chan_scale (
  input  logic [tfc_pkg::CHAN_W-1:0]  raw,
  input  tfc_pkg::src_fmt_t           src_fmt,
  input  tfc_pkg::max_sel_t           max_sel,
  output logic [tfc_pkg::SCALE_W-1:0] scaled
);
  import tfc_pkg::*;

  logic [CHAN_W-1:0] val;
  logic [PROD_W-1:0] val_w;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   sum_byte;
  logic [PROD_W:0]   sum_short;

  // offset binary for the signed formats is a flip of the sign bit
  always_comb begin
    case (src_fmt)
      SRC_S8:  val = {8'd0, raw[7:0] ^ 8'h80};
      SRC_U8:  val = {8'd0, raw[7:0]};
      SRC_S16: val = raw ^ 16'h8000;
      SRC_U16: val = raw;
      default: val = raw;
    endcase
  end

  assign val_w = {{(PROD_W-CHAN_W){1'b0}}, val};

  // full scale is 2^m - 1, so the product is a shift and a subtract
  always_comb begin
    case (max_sel)
      MAX_15:  prod = (val_w << 4) - val_w;
      MAX_31:  prod = (val_w << 5) - val_w;
      MAX_63:  prod = (val_w << 6) - val_w;
      default: prod = (val_w << 6) - val_w;
    endcase
  end

  // floor(p / (2^n - 1)) = (p + (p >> n) + 1) >> n for p well below 2^(2n)
  assign sum_byte  = {1'b0, prod} + {9'd0, prod[PROD_W-1:8]} + 23'd1;
  assign sum_short = {1'b0, prod} + {17'd0, prod[PROD_W-1:16]} + 23'd1;

  assign scaled = src_fmt[1] ? sum_short[21:16] : sum_byte[13:8];

endmodule

FILE: sv/texel_format_converter.sv
`timescale 1ns / 1ps
// texel_format_converter: one source pixel in, one 16-bit texel out
//
// input channel: a pixel beat is taken on a rising clk edge with start high
//   and busy low; in_red/in_green/in_blue/in_alpha carry raw channel bits
//   (low byte only for the byte formats), in_last tags the final pixel
// result channel: out_valid strobes for exactly one cycle with out_texel and
//   out_last; the receiver must take it then, there is no stall path
// config channel: cfg_valid/cfg_ready write cfg_data into register cfg_index
//   (0 source format, 1 alpha enable); cfg_ready is always high, writes are
//   expected only while no pixel is in flight
// data path: an accepted pixel goes through the input register, then the
//   result register, which drives the result ports
// throughput: one pixel per cycle while busy is low, set by the single
//   combinational pass of four channel scalers and the packer between the
//   two registers
// reset: synchronous, active low; clears the pipeline valids and loads
//   unsigned byte source with RGB565 output; busy is set in reset and its
//   register clears once rst_n is high

module texel_format_converter (
  input  logic                           clk,
  input  logic                           rst_n,
  // pixel input
  input  logic                           start,
  output logic                           busy,
  input  logic [tfc_pkg::CHAN_W-1:0]     in_red,
  input  logic [tfc_pkg::CHAN_W-1:0]     in_green,
  input  logic [tfc_pkg::CHAN_W-1:0]     in_blue,
  input  logic [tfc_pkg::CHAN_W-1:0]     in_alpha,
  input  logic                           in_last,
  // texel output
  output logic                           out_valid,
  output logic [tfc_pkg::TEXEL_W-1:0]    out_texel,
  output logic                           out_last,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tfc_pkg::*;

  `include "texel_format_converter_assert.svh"

  tfc_cfg_t cfg;

  logic accept;

  // input register stage
  logic              busy_r;
  logic              stg_vld_r;
  logic [CHAN_W-1:0] stg_red_r, stg_green_r, stg_blue_r, stg_alpha_r;
  logic              stg_last_r;

  // scaled channels
  logic [SCALE_W-1:0] red_s, green_s, blue_s, alpha_s;
  max_sel_t           rb_max, g_max;
  logic [TEXEL_W-1:0] texel_nxt;

  // result register stage
  logic               out_valid_r;
  logic [TEXEL_W-1:0] out_texel_r;
  logic               out_last_r;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;
  assign accept    = start && !busy_r;

  tfc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // busy only covers the reset window, the pipe never backs up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      stg_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      stg_vld_r   <= accept;
      out_valid_r <= stg_vld_r;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_red_r   <= in_red;
      stg_green_r <= in_green;
      stg_blue_r  <= in_blue;
      stg_alpha_r <= in_alpha;
      stg_last_r  <= in_last;
    end
    if (stg_vld_r) begin
      out_texel_r <= texel_nxt;
      out_last_r  <= stg_last_r;
    end
  end

  // ARGB4444 uses 4-bit channels, RGB565 uses 5/6/5
  assign rb_max = cfg.with_alpha ? MAX_15 : MAX_31;
  assign g_max  = cfg.with_alpha ? MAX_15 : MAX_63;

  tfc_chan_scale u_red (
    .raw     (stg_red_r),
    .src_fmt (cfg.src_fmt),
    .max_sel (rb_max),
    .scaled  (red_s)
  );

  tfc_chan_scale u_green (
    .raw     (stg_green_r),
    .src_fmt (cfg.src_fmt),
    .max_sel (g_max),
    .scaled  (green_s)
  );

  tfc_chan_scale u_blue (
    .raw     (stg_blue_r),
    .src_fmt (cfg.src_fmt),
    .max_sel (rb_max),
    .scaled  (blue_s)
  );

  // alpha result is dropped in RGB565 mode
  tfc_chan_scale u_alpha (
    .raw     (stg_alpha_r),
    .src_fmt (cfg.src_fmt),
    .max_sel (MAX_15),
    .scaled  (alpha_s)
  );

  // texel packing
  always_comb begin
    if (cfg.with_alpha) begin
      texel_nxt = {alpha_s[3:0], red_s[3:0], green_s[3:0], blue_s[3:0]};
    end else begin
      texel_nxt = {red_s[4:0], green_s[5:0], blue_s[4:0]};
    end
  end

  assign out_valid = out_valid_r;
  assign out_texel = out_texel_r;
  assign out_last  = out_last_r;

  // every accepted beat reaches the input stage
  `TFC_ASSERT_NEXT(a_accept_to_stage, accept, stg_vld_r, "accepted beat lost at input stage")
  // input stage always drains into the result register
  `TFC_ASSERT_NEXT(a_stage_to_out, stg_vld_r, out_valid_r, "staged beat lost at result stage")
  // no strobe without a staged beat behind it
  `TFC_ASSERT_NEXT(a_no_phantom, !stg_vld_r, !out_valid_r, "result strobe without staged beat")
  // last flag follows its pixel
  `TFC_ASSERT_NEXT(a_last_follows, stg_vld_r, out_last_r == $past(stg_last_r),
                   "last flag not carried with its texel")
  // no beat is taken while busy
  `TFC_ASSERT_NOW(a_no_accept_busy, busy_r, !accept, "beat accepted while busy")

endmodule
